/* hw/rtl/ure_pkg.sv */
// shared constants for the ultrasonic echo ranger
package ure_pkg;

   localparam int TIMER_BITS_DEFAULT = 20;

   localparam int OPCODE_BITS   = 2;
   localparam int STATUS_BITS   = 2;
   localparam int TIMEOUT_BITS  = 20;
   localparam int DURATION_BITS = 20;
   localparam int DISTANCE_BITS = 23;

   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_MIN   = TIMEOUT_BITS'(1000);
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(30000);

   // distance in 1/256 cm is duration * 4496 / 1024
   localparam int DIST_MUL_BITS = 13;
   localparam logic [DIST_MUL_BITS-1:0] DIST_MUL = DIST_MUL_BITS'(4496);
   localparam int DIST_SHIFT = 10;
   localparam int PRODUCT_BITS = DURATION_BITS + DIST_MUL_BITS;

   localparam logic [OPCODE_BITS-1:0] OP_TRIGGER = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_ECHO    = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_TICK    = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_STARTED = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_BUSY    = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_DONE    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_TIMEOUT = 2'd3;

endpackage

/* hw/rtl/ultrasonic_echo_ranger.sv */
// echo-ranging sequencer: trigger, echo edge and tick transactions in, status and distance out
//
// The block takes one transaction every clock while req_stall is low, with no gap needed
// between transactions. Each transaction updates the measurement state at the edge that
// accepts it. A transaction that produces a result is captured in a stage register
// at that edge and moves into the response register, through the constant
// duration-to-distance multiply, once the response register is empty or its result is
// taken; rsp_valid rises as it moves. The input stalls only while the stage register holds
// a result and the response register holds a stalled one.
// Trigger, tick and falling-edge transactions may yield a status; rising edges,
// ticks before timeout and ignored codes yield none. Writing timeout_us clamps
// values below 1000 to 1000 and restarts the tick counter; write it only while
// no transaction is in flight.
module ultrasonic_echo_ranger #(
   parameter int TIMER_BITS = ure_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ure_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  logic                               req_echo_level,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ure_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [ure_pkg::DURATION_BITS-1:0]  rsp_duration_us,
   output logic [ure_pkg::DISTANCE_BITS-1:0]  rsp_distance_q8,

   input  logic                               csr_wr_en,
   input  logic [ure_pkg::TIMEOUT_BITS-1:0]   csr_wr_data
);

   localparam int CMP_BITS = (TIMER_BITS > ure_pkg::TIMEOUT_BITS) ?
                             TIMER_BITS : ure_pkg::TIMEOUT_BITS;
   localparam logic [TIMER_BITS-1:0] COUNT_MAX = {TIMER_BITS{1'b1}};

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RISE = 2'd1;
   localparam logic [1:0] PH_FALL = 2'd2;

   logic [1:0]                              phase_ff, phase_in;
   logic [TIMER_BITS-1:0]                   elapsed_ff, elapsed_in;
   logic [TIMER_BITS-1:0]                   start_ff, start_in;
   logic [ure_pkg::TIMEOUT_BITS-1:0]        timeout_ff, timeout_in;

   logic                                    s1_valid_ff, s1_valid_in;
   logic [ure_pkg::STATUS_BITS-1:0]         s1_status_ff;
   logic [ure_pkg::DURATION_BITS-1:0]       s1_duration_ff;

   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [ure_pkg::STATUS_BITS-1:0]         rsp_status_ff;
   logic [ure_pkg::DURATION_BITS-1:0]       rsp_duration_ff;
   logic [ure_pkg::DISTANCE_BITS-1:0]       rsp_distance_ff;

   logic                                    out_ready;
   logic                                    req_accept;
   logic                                    emit;
   logic [ure_pkg::STATUS_BITS-1:0]         emit_status;
   logic [ure_pkg::DURATION_BITS-1:0]       emit_duration;
   logic [TIMER_BITS-1:0]                   tick_count;
   logic [TIMER_BITS-1:0]                   pulse_width;
   logic [ure_pkg::PRODUCT_BITS-1:0]        product;

   // handshake
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   assign tick_count  = (elapsed_ff < COUNT_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign pulse_width = (elapsed_ff >= start_ff) ? elapsed_ff - start_ff : '0;

   // measurement state update
   always_comb begin
      phase_in      = phase_ff;
      elapsed_in    = elapsed_ff;
      start_in      = start_ff;
      timeout_in    = timeout_ff;
      emit          = 1'b0;
      emit_status   = ure_pkg::ST_STARTED;
      emit_duration = '0;
      if (req_accept) begin
         unique case (req_opcode)
            ure_pkg::OP_TRIGGER: begin
               emit = 1'b1;
               if (phase_ff != PH_IDLE) begin
                  emit_status = ure_pkg::ST_BUSY;
               end else begin
                  emit_status = ure_pkg::ST_STARTED;
                  phase_in    = PH_RISE;
                  elapsed_in  = '0;
                  start_in    = '0;
               end
            end
            ure_pkg::OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  elapsed_in = tick_count;
                  if (CMP_BITS'(tick_count) >= CMP_BITS'(timeout_ff) ||
                      tick_count == COUNT_MAX) begin
                     emit        = 1'b1;
                     emit_status = ure_pkg::ST_TIMEOUT;
                     phase_in    = PH_IDLE;
                     elapsed_in  = '0;
                  end
               end
            end
            ure_pkg::OP_ECHO: begin
               if (req_echo_level) begin
                  if (phase_ff == PH_RISE) begin
                     start_in = elapsed_ff;
                     phase_in = PH_FALL;
                  end
               end else if (phase_ff == PH_FALL) begin
                  emit          = 1'b1;
                  emit_status   = ure_pkg::ST_DONE;
                  emit_duration = ure_pkg::DURATION_BITS'(pulse_width);
                  phase_in      = PH_IDLE;
                  elapsed_in    = '0;
               end
            end
            default: begin
            end
         endcase
      end
      if (csr_wr_en) begin
         timeout_in = (csr_wr_data < ure_pkg::TIMEOUT_MIN) ? ure_pkg::TIMEOUT_MIN : csr_wr_data;
         elapsed_in = '0;
      end
   end

   always_comb begin
      if (req_accept) begin
         s1_valid_in = emit;
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
   end

   assign product = ure_pkg::PRODUCT_BITS'(s1_duration_ff) *
                    ure_pkg::PRODUCT_BITS'(ure_pkg::DIST_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         elapsed_ff   <= '0;
         start_ff     <= '0;
         timeout_ff   <= ure_pkg::TIMEOUT_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         start_ff     <= start_in;
         timeout_ff   <= timeout_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         s1_status_ff   <= emit_status;
         s1_duration_ff <= emit_duration;
      end
      if (out_ready && s1_valid_ff) begin
         rsp_status_ff   <= s1_status_ff;
         rsp_duration_ff <= s1_duration_ff;
         rsp_distance_ff <= ure_pkg::DISTANCE_BITS'(product >> ure_pkg::DIST_SHIFT);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_duration_us = rsp_duration_ff;
   assign rsp_distance_q8 = rsp_distance_ff;

   // idle always leaves the counter cleared
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (elapsed_ff == '0))
      else $error("counter not cleared while idle");

   // the stored timeout never falls below the clamp
   assert property (@(posedge clock) disable iff (reset)
      timeout_ff >= ure_pkg::TIMEOUT_MIN)
      else $error("timeout below minimum");

   // a trigger taken while idle arms the echo wait and queues a started status
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_opcode == ure_pkg::OP_TRIGGER && phase_ff == PH_IDLE)
      |=> (phase_ff == PH_RISE && s1_valid_ff && s1_status_ff == ure_pkg::ST_STARTED))
      else $error("trigger did not start measurement");

   // only a done status carries a duration
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ure_pkg::ST_DONE)
      |-> (rsp_duration_ff == '0 && rsp_distance_ff == '0))
      else $error("nonzero measurement on non-done status");

   // the input stalls only behind a held response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("spurious input stall");

endmodule
